[hdl/sfl_pkg.sv]
// Package for the segregated free-list store.
// Holds the sizes, codes and entry types shared by the store and its memories.
// No dependencies.
package sfl_pkg;

   localparam int MAX_CLASSES = 64;
   localparam int NUM_BLOCKS  = 4096;
   localparam int SIZE_BITS   = 16;

   localparam int CLASS_IDX_W = $clog2(MAX_CLASSES);
   localparam int COUNT_W     = $clog2(MAX_CLASSES + 1);
   localparam int BLK_W       = $clog2(NUM_BLOCKS);

   localparam logic [1:0] MODE_RECLAIM = 2'd0;
   localparam logic [1:0] MODE_RECYCLE = 2'd1;
   localparam logic [1:0] MODE_CLEAR   = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic [SIZE_BITS-1:0] size;
      logic [BLK_W-1:0]     head;
      logic                 nonempty;
   } class_entry_type;

   typedef struct packed {
      logic             valid;
      logic [BLK_W-1:0] link;
   } link_entry_type;

   typedef struct packed {
      logic                   wr_en;
      logic [CLASS_IDX_W-1:0] wr_addr;
      class_entry_type        wr_data;
      logic [CLASS_IDX_W-1:0] rd_addr;
   } class_port_type;

   typedef struct packed {
      logic             wr_en;
      logic [BLK_W-1:0] wr_addr;
      link_entry_type   wr_data;
      logic [BLK_W-1:0] rd_addr;
   } link_port_type;

endpackage

[hdl/sfl_class_ram.sv]
// Size class table memory: one write port and one registered read port.
// Depends on sfl_pkg.
module sfl_class_ram
   import sfl_pkg::*;
(
   input  logic            clock,
   input  class_port_type  port,
   output class_entry_type rd_data
);

   class_entry_type mem [MAX_CLASSES];
   class_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (port.wr_en) begin
         mem[port.wr_addr] <= port.wr_data;
      end
      rd_data_ff <= mem[port.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/sfl_link_ram.sv]
// Link memory holding the next block of every listed block.
// Depends on sfl_pkg.
module sfl_link_ram
   import sfl_pkg::*;
(
   input  logic           clock,
   input  link_port_type  port,
   output link_entry_type rd_data
);

   link_entry_type mem [NUM_BLOCKS];
   link_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (port.wr_en) begin
         mem[port.wr_addr] <= port.wr_data;
      end
      rd_data_ff <= mem[port.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/segregated_free_list_store.sv]
// Segregated free-list store: one LIFO list of freed blocks per exact block size, with
// the size classes kept sorted in a table that a single comparator searches by binary
// search, each probe a table read and then a compare. A recycle hit adds one link
// memory read. A reclaim of a new size shifts every class above its sorted place up
// by one, a table read and then a table write for each, since the table has one read
// and one write port. Clear and unused modes answer straight from idle, without a
// search. One request is worked on at a time, and the next is taken only when the
// output register is empty or its response leaves at that edge.
// Depends on sfl_pkg, sfl_class_ram and sfl_link_ram.
module segregated_free_list_store
   import sfl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_mode,
   input  logic [BLK_W-1:0]     req_block_index,
   input  logic [SIZE_BITS-1:0] req_size_words,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_hit,
   output logic [BLK_W-1:0]     rsp_block_out,
   output logic [1:0]           rsp_status
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_POP
   } state_type;

   state_type            state_ff;
   logic [1:0]           mode_ff;
   logic [BLK_W-1:0]     blk_ff;
   logic [SIZE_BITS-1:0] size_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [COUNT_W-1:0]   lo_ff;
   logic [COUNT_W-1:0]   hi_ff;
   logic [COUNT_W-1:0]   idx_ff;
   logic [CLASS_IDX_W-1:0] mid_ff;
   logic [BLK_W-1:0]     head_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [BLK_W-1:0]     rsp_block_out_ff;
   logic [1:0]           rsp_status_ff;

   class_port_type  cls_port;
   class_entry_type cls_rd;
   link_port_type   lnk_port;
   link_entry_type  lnk_rd;

   logic [COUNT_W:0]   mid_sum;
   logic [COUNT_W-1:0] mid;
   logic [COUNT_W-1:0] idx_dec;
   logic               size_eq;
   logic               size_lt;
   logic               accept;

   sfl_class_ram u_class_ram (
      .clock   (clock),
      .port    (cls_port),
      .rd_data (cls_rd)
   );

   sfl_link_ram u_link_ram (
      .clock   (clock),
      .port    (lnk_port),
      .rd_data (lnk_rd)
   );

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[COUNT_W:1];
   assign idx_dec = idx_ff - COUNT_W'(1);
   assign size_eq = (cls_rd.size == size_ff);
   assign size_lt = (cls_rd.size < size_ff);

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cls_port         = '0;
      lnk_port         = '0;
      cls_port.rd_addr = mid[CLASS_IDX_W-1:0];
      lnk_port.rd_addr = cls_rd.head;
      unique case (state_ff)
         S_CMP: begin
            if (size_eq && (mode_ff == MODE_RECLAIM)) begin
               lnk_port.wr_en         = 1'b1;
               lnk_port.wr_addr       = blk_ff;
               lnk_port.wr_data.valid = cls_rd.nonempty;
               lnk_port.wr_data.link  = cls_rd.head;
               cls_port.wr_en         = 1'b1;
               cls_port.wr_addr       = mid_ff;
               cls_port.wr_data       = '{size: size_ff, head: blk_ff, nonempty: 1'b1};
            end
         end
         S_SHIFT_RD: begin
            cls_port.rd_addr = idx_dec[CLASS_IDX_W-1:0];
            if (idx_ff <= lo_ff) begin
               lnk_port.wr_en   = 1'b1;
               lnk_port.wr_addr = blk_ff;
               cls_port.wr_en   = 1'b1;
               cls_port.wr_addr = lo_ff[CLASS_IDX_W-1:0];
               cls_port.wr_data = '{size: size_ff, head: blk_ff, nonempty: 1'b1};
            end
         end
         S_SHIFT_WR: begin
            cls_port.wr_en   = 1'b1;
            cls_port.wr_addr = idx_ff[CLASS_IDX_W-1:0];
            cls_port.wr_data = cls_rd;
         end
         S_POP: begin
            cls_port.wr_en   = 1'b1;
            cls_port.wr_addr = mid_ff;
            if (lnk_rd.valid) begin
               cls_port.wr_data = '{size: size_ff, head: lnk_rd.link, nonempty: 1'b1};
            end else begin
               cls_port.wr_data = '{size: size_ff, head: head_ff, nonempty: 1'b0};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  mode_ff <= req_mode;
                  blk_ff  <= req_block_index;
                  size_ff <= req_size_words;
                  lo_ff   <= '0;
                  hi_ff   <= count_ff;
                  if ((req_mode == MODE_RECLAIM) || (req_mode == MODE_RECYCLE)) begin
                     state_ff <= S_SEARCH;
                  end else begin
                     if (req_mode == MODE_CLEAR) begin
                        count_ff <= '0;
                     end
                     rsp_valid_ff     <= 1'b1;
                     rsp_hit_ff       <= 1'b0;
                     rsp_block_out_ff <= '0;
                     rsp_status_ff    <= ST_OK;
                  end
               end
            end
            S_SEARCH: begin
               if (lo_ff < hi_ff) begin
                  mid_ff   <= mid[CLASS_IDX_W-1:0];
                  state_ff <= S_CMP;
               end else if (mode_ff == MODE_RECYCLE) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_hit_ff       <= 1'b0;
                  rsp_block_out_ff <= '0;
                  rsp_status_ff    <= ST_MISS;
                  state_ff         <= S_IDLE;
               end else if (count_ff == COUNT_W'(MAX_CLASSES)) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_hit_ff       <= 1'b0;
                  rsp_block_out_ff <= '0;
                  rsp_status_ff    <= ST_FULL;
                  state_ff         <= S_IDLE;
               end else begin
                  idx_ff   <= count_ff;
                  state_ff <= S_SHIFT_RD;
               end
            end
            S_CMP: begin
               if (size_eq) begin
                  head_ff <= cls_rd.head;
                  if ((mode_ff == MODE_RECYCLE) && cls_rd.nonempty) begin
                     state_ff <= S_POP;
                  end else begin
                     rsp_valid_ff     <= 1'b1;
                     rsp_hit_ff       <= 1'b0;
                     rsp_block_out_ff <= '0;
                     rsp_status_ff    <= (mode_ff == MODE_RECYCLE) ? ST_MISS : ST_OK;
                     state_ff         <= S_IDLE;
                  end
               end else begin
                  if (size_lt) begin
                     lo_ff <= {1'b0, mid_ff} + COUNT_W'(1);
                  end else begin
                     hi_ff <= {1'b0, mid_ff};
                  end
                  state_ff <= S_SEARCH;
               end
            end
            S_SHIFT_RD: begin
               if (idx_ff > lo_ff) begin
                  state_ff <= S_SHIFT_WR;
               end else begin
                  count_ff         <= count_ff + COUNT_W'(1);
                  rsp_valid_ff     <= 1'b1;
                  rsp_hit_ff       <= 1'b0;
                  rsp_block_out_ff <= '0;
                  rsp_status_ff    <= ST_OK;
                  state_ff         <= S_IDLE;
               end
            end
            S_SHIFT_WR: begin
               idx_ff   <= idx_dec;
               state_ff <= S_SHIFT_RD;
            end
            S_POP: begin
               rsp_valid_ff     <= 1'b1;
               rsp_hit_ff       <= 1'b1;
               rsp_block_out_ff <= head_ff;
               rsp_status_ff    <= ST_OK;
               state_ff         <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_block_out = rsp_block_out_ff;
   assign rsp_status    = rsp_status_ff;

   // The class count never grows past the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_CLASSES))
      else $error("class count beyond table depth");

   // The search window stays ordered and inside the table while searching.
   a_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> (lo_ff <= hi_ff) && (hi_ff <= count_ff))
      else $error("search window out of order");

   // A clear request empties the table at once.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_mode == MODE_CLEAR)) |=> (count_ff == '0))
      else $error("clear did not empty the table");

   // A returned block always comes with an ok status.
   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_hit_ff) |-> (rsp_status_ff == ST_OK))
      else $error("hit with error status");

endmodule
